@@ rtl/adam_update_engine_top_defines.svh @@
// Assertion macros shared by the RTL.
`ifndef ADAM_UPDATE_ENGINE_TOP_DEFINES_SVH
`define ADAM_UPDATE_ENGINE_TOP_DEFINES_SVH

// Check under the clock, masked while reset is held.
`define AUE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check under the clock, also during reset.
`define AUE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ rtl/aue_pkg.sv @@
`default_nettype none
package aue_pkg;

    localparam int NUM_PARAMS = 2048;
    localparam int ADDR_W     = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;

    localparam logic [24:0] Q24_ONE  = 25'h1000000;
    localparam logic [23:0] Q24_HALF = 24'h800000;

    localparam logic [23:0] LR_RESET  = 24'd16777;
    localparam logic [23:0] B1_RESET  = 24'd15099494;
    localparam logic [23:0] B2_RESET  = 24'd16760438;
    localparam logic [23:0] EPS_RESET = 24'd168;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_DECAY       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_DECAY      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DENOMINATOR_FLOOR = 3'd3;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_MUL_D,
        ST_MUL_E,
        ST_MUL_F,
        ST_MUL_G,
        ST_MUL_H,
        ST_VN,
        ST_DIV_M,
        ST_DIV_V,
        ST_SQRT,
        ST_UMUL,
        ST_ULOAD,
        ST_DIV_U,
        ST_POW1,
        ST_POW2,
        ST_POW3,
        ST_OUT
    } aue_state_t;

endpackage
`default_nettype wire

@@ rtl/adam_update_engine_top.sv @@
// Steps for an in-range request: memory read, multiplies, the divides for mhat and vhat,
//   square root and update divide, then power steps at end of pass; a saturating divide stops at load.
// One request is taken at a time; s_tready is high only in idle.
// A finished result waits in the output register while the next request is taken.
// Reset (aresetn low, synchronous) loads register defaults, then a clearing pass
//   zeroes both moment memories; no request is taken during it.
`default_nettype none
`include "adam_update_engine_top_defines.svh"
module adam_update_engine_top (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // s_tdata: gradient [31:0], element_index [42:32], zero fill
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [47:0]                      s_tdata,
    input  wire logic                             s_tlast,     // end_of_pass
    // m_tdata: update_value [31:0], update_index [42:32], zero fill
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [47:0]                           m_tdata,
    input  wire logic                             cfg_wr_en,
    input  wire logic [aue_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [23:0]                      cfg_wdata
);

    // ---------------------------------------------------------------
    // Sequencer state
    // ---------------------------------------------------------------
    aue_pkg::aue_state_t state_reg, state_next;
    logic [aue_pkg::ADDR_W-1:0] clr_cnt_reg;

    // Configuration and running beta powers
    logic [23:0] lr_reg, b1_reg, b2_reg, eps_reg;
    logic [23:0] p1_reg, p2_reg;

    // Request payload held for the whole computation
    logic signed [31:0] grad_reg;
    logic [10:0]        idx_reg;
    logic               last_reg;
    logic               inrange;

    // Moment memories and their registered read data
    logic signed [31:0] m_mem [aue_pkg::NUM_PARAMS];
    logic [47:0]        v_mem [aue_pkg::NUM_PARAMS];
    logic signed [31:0] rd_m_reg;
    logic [47:0]        rd_v_reg;
    logic                        mem_we;
    logic [aue_pkg::ADDR_W-1:0]  mem_addr;
    logic signed [31:0]          mem_wm;
    logic [47:0]                 mem_wv;

    // Shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_next, prod_reg;

    // Intermediate values
    logic signed [57:0] acc_reg, acc_sh;
    logic signed [31:0] mn_sat, mn_reg;
    logic [62:0]        g2_sum;
    logic [46:0]        g2_reg;
    logic [49:0]        hi_reg, lo_reg, vn_sum;
    logic [47:0]        vn, vn_reg;
    logic signed [31:0] mhat_reg, upd_reg;
    logic [40:0]        den_reg;
    logic [24:0]        c1, c2, d1, d2;
    logic [31:0]        ag, abs_mn;
    logic [65:0]        pabs;
    logic [48:0]        pw_sum;

    // Shared divider
    logic [40:0] div_rem_reg, div_den_reg;
    logic [63:0] div_quo_reg;
    logic [6:0]  div_cnt_reg;
    logic        div_ovf_reg, div_neg_reg;
    logic        div_ld, div_active, div_done, div_ge;
    logic [40:0] div_ld_hi, div_ld_den;
    logic [63:0] div_ld_lo;
    logic [6:0]  div_ld_cnt;
    logic        div_ld_neg, div_ld_ovf;
    logic [41:0] div_rem2, div_diff;
    logic signed [31:0] div_sat;
    logic [63:0] vhat;

    // Square root
    logic [63:0] sq_x_reg;
    logic [31:0] sq_root_reg;
    logic [33:0] sq_rem_reg, sq_rem2, sq_trial;
    logic [5:0]  sq_cnt_reg;
    logic        sq_small_reg, sq_ge;
    logic [39:0] sq_s;
    logic [40:0] den_sum;

    logic out_free;

    function automatic logic signed [31:0] sat_mag(input logic neg, input logic ovf,
                                                   input logic [31:0] mag);
        logic signed [31:0] r;
        if (ovf) begin
            r = neg ? aue_pkg::SAT_MIN : aue_pkg::SAT_MAX;
        end else if (!neg) begin
            r = mag[31] ? aue_pkg::SAT_MAX : signed'(mag);
        end else if (mag > 32'h80000000) begin
            r = aue_pkg::SAT_MIN;
        end else begin
            r = signed'(~mag + 32'd1);
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Arithmetic helpers
    // ---------------------------------------------------------------
    assign inrange   = 32'(idx_reg) < aue_pkg::NUM_PARAMS;
    assign c1        = aue_pkg::Q24_ONE - {1'b0, b1_reg};
    assign c2        = aue_pkg::Q24_ONE - {1'b0, b2_reg};
    assign d1        = aue_pkg::Q24_ONE - {1'b0, p1_reg};
    assign d2        = aue_pkg::Q24_ONE - {1'b0, p2_reg};
    assign ag        = grad_reg[31] ? 32'(-grad_reg) : 32'(grad_reg);
    assign abs_mn    = mn_reg[31] ? 32'(-mn_reg) : 32'(mn_reg);
    assign pabs      = prod_reg[65] ? 66'(-prod_reg) : 66'(prod_reg);
    assign prod_next = mul_a * mul_b;

    // First moment: floor shift then saturate
    assign acc_sh = acc_reg >>> 24;
    assign mn_sat = (acc_sh > 58'sd2147483647) ? aue_pkg::SAT_MAX :
                    (acc_sh < -58'sd2147483648) ? aue_pkg::SAT_MIN : acc_sh[31:0];

    // Squared gradient, rounded to Q31.16
    assign g2_sum = prod_reg[62:0] + 63'd32768;

    // Second moment from split high and low partial sums
    assign vn_sum = hi_reg + {24'd0, lo_reg[49:24]};
    assign vn     = (vn_sum[49:48] != 2'd0) ? 48'hFFFFFFFFFFFF : vn_sum[47:0];

    // Power step rounding
    assign pw_sum = prod_reg[48:0] + {25'd0, aue_pkg::Q24_HALF};

    // Divider step: one quotient bit per cycle
    assign div_active = (state_reg == aue_pkg::ST_DIV_M) || (state_reg == aue_pkg::ST_DIV_V) ||
                        (state_reg == aue_pkg::ST_DIV_U);
    assign div_done   = (div_cnt_reg == 7'd0);
    assign div_rem2   = {div_rem_reg, div_quo_reg[63]};
    assign div_ge     = div_rem2 >= {1'b0, div_den_reg};
    assign div_diff   = div_rem2 - {1'b0, div_den_reg};
    assign div_sat    = sat_mag(div_neg_reg, div_ovf_reg, div_quo_reg[31:0]);
    assign vhat       = div_ovf_reg ? 64'hFFFFFFFFFFFFFFFF : div_quo_reg;
    assign div_ld_ovf = div_ld_hi >= div_ld_den;

    // Square root step: one root bit per cycle
    assign sq_rem2  = {sq_rem_reg[31:0], sq_x_reg[63:62]};
    assign sq_trial = {sq_root_reg, 2'b01};
    assign sq_ge    = sq_rem2 >= sq_trial;
    assign sq_s     = sq_small_reg ? {8'd0, sq_root_reg} : {sq_root_reg, 8'd0};
    assign den_sum  = {1'b0, sq_s} + {17'd0, eps_reg};

    assign out_free = !m_tvalid || m_tready;

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            aue_pkg::ST_CLEAR: begin
                if (clr_cnt_reg == aue_pkg::ADDR_W'(aue_pkg::NUM_PARAMS - 1)) begin
                    state_next = aue_pkg::ST_IDLE;
                end
            end
            aue_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = aue_pkg::ST_READ;
                end
            end
            aue_pkg::ST_READ: begin
                if (inrange) begin
                    state_next = aue_pkg::ST_MUL_A;
                end else begin
                    state_next = last_reg ? aue_pkg::ST_POW1 : aue_pkg::ST_OUT;
                end
            end
            aue_pkg::ST_MUL_A: state_next = aue_pkg::ST_MUL_B;
            aue_pkg::ST_MUL_B: state_next = aue_pkg::ST_MUL_C;
            aue_pkg::ST_MUL_C: state_next = aue_pkg::ST_MUL_D;
            aue_pkg::ST_MUL_D: state_next = aue_pkg::ST_MUL_E;
            aue_pkg::ST_MUL_E: state_next = aue_pkg::ST_MUL_F;
            aue_pkg::ST_MUL_F: state_next = aue_pkg::ST_MUL_G;
            aue_pkg::ST_MUL_G: state_next = aue_pkg::ST_MUL_H;
            aue_pkg::ST_MUL_H: state_next = aue_pkg::ST_VN;
            aue_pkg::ST_VN:    state_next = aue_pkg::ST_DIV_M;
            aue_pkg::ST_DIV_M: begin
                if (div_done) begin
                    state_next = aue_pkg::ST_DIV_V;
                end
            end
            aue_pkg::ST_DIV_V: begin
                if (div_done) begin
                    state_next = aue_pkg::ST_SQRT;
                end
            end
            aue_pkg::ST_SQRT: begin
                if (sq_cnt_reg == 6'd0) begin
                    state_next = aue_pkg::ST_UMUL;
                end
            end
            aue_pkg::ST_UMUL:  state_next = aue_pkg::ST_ULOAD;
            aue_pkg::ST_ULOAD: state_next = aue_pkg::ST_DIV_U;
            aue_pkg::ST_DIV_U: begin
                if (div_done) begin
                    state_next = last_reg ? aue_pkg::ST_POW1 : aue_pkg::ST_OUT;
                end
            end
            aue_pkg::ST_POW1: state_next = aue_pkg::ST_POW2;
            aue_pkg::ST_POW2: state_next = aue_pkg::ST_POW3;
            aue_pkg::ST_POW3: state_next = aue_pkg::ST_OUT;
            aue_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = aue_pkg::ST_IDLE;
                end
            end
            default: state_next = aue_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer outputs: multiplier operands, memory write, divider loads
    // ---------------------------------------------------------------
    always_comb begin
        s_tready   = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        mem_we     = 1'b0;
        mem_addr   = aue_pkg::ADDR_W'(idx_reg);
        mem_wm     = mn_reg;
        mem_wv     = vn;
        div_ld     = 1'b0;
        div_ld_hi  = '0;
        div_ld_lo  = '0;
        div_ld_den = {16'd0, d1};
        div_ld_cnt = 7'd32;
        div_ld_neg = 1'b0;
        case (state_reg)
            aue_pkg::ST_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = clr_cnt_reg;
                mem_wm   = '0;
                mem_wv   = '0;
            end
            aue_pkg::ST_IDLE: s_tready = 1'b1;
            aue_pkg::ST_MUL_A: begin
                mul_a = {9'd0, b1_reg};
                mul_b = {rd_m_reg[31], rd_m_reg};
            end
            aue_pkg::ST_MUL_B: begin
                mul_a = {8'd0, c1};
                mul_b = {grad_reg[31], grad_reg};
            end
            aue_pkg::ST_MUL_C: begin
                mul_a = {1'b0, ag};
                mul_b = {1'b0, ag};
            end
            aue_pkg::ST_MUL_D: begin
                mul_a = {9'd0, b2_reg};
                mul_b = {9'd0, rd_v_reg[47:24]};
            end
            aue_pkg::ST_MUL_E: begin
                mul_a = {8'd0, c2};
                mul_b = {10'd0, g2_reg[46:24]};
            end
            aue_pkg::ST_MUL_F: begin
                mul_a = {9'd0, b2_reg};
                mul_b = {9'd0, rd_v_reg[23:0]};
            end
            aue_pkg::ST_MUL_G: begin
                mul_a = {8'd0, c2};
                mul_b = {9'd0, g2_reg[23:0]};
            end
            aue_pkg::ST_VN: begin
                // commit moments, start mhat = |m'| * 2^24 / (1 - p1)
                mem_we     = 1'b1;
                div_ld     = 1'b1;
                div_ld_hi  = {17'd0, abs_mn[31:8]};
                div_ld_lo  = {abs_mn[7:0], 56'd0};
                div_ld_den = {16'd0, d1};
                div_ld_cnt = 7'd32;
                div_ld_neg = mn_reg[31];
            end
            aue_pkg::ST_DIV_M: begin
                // start vhat = v' * 2^24 / (1 - p2)
                div_ld     = div_done;
                div_ld_hi  = {33'd0, vn_reg[47:40]};
                div_ld_lo  = {vn_reg[39:0], 24'd0};
                div_ld_den = {16'd0, d2};
                div_ld_cnt = 7'd64;
            end
            aue_pkg::ST_UMUL: begin
                mul_a = {9'd0, lr_reg};
                mul_b = {mhat_reg[31], mhat_reg};
            end
            aue_pkg::ST_ULOAD: begin
                div_ld     = 1'b1;
                div_ld_hi  = {17'd0, pabs[55:32]};
                div_ld_lo  = {pabs[31:0], 32'd0};
                div_ld_den = den_reg;
                div_ld_cnt = 7'd32;
                div_ld_neg = prod_reg[65];
            end
            aue_pkg::ST_POW1: begin
                mul_a = {9'd0, p1_reg};
                mul_b = {9'd0, b1_reg};
            end
            aue_pkg::ST_POW2: begin
                mul_a = {9'd0, p2_reg};
                mul_b = {9'd0, b2_reg};
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // Control registers, configuration and beta powers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= aue_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            lr_reg      <= aue_pkg::LR_RESET;
            b1_reg      <= aue_pkg::B1_RESET;
            b2_reg      <= aue_pkg::B2_RESET;
            eps_reg     <= aue_pkg::EPS_RESET;
            p1_reg      <= aue_pkg::B1_RESET;
            p2_reg      <= aue_pkg::B2_RESET;
        end else begin
            state_reg <= state_next;
            if (state_reg == aue_pkg::ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            // advance the powers at the end of a pass
            if (state_reg == aue_pkg::ST_POW2) begin
                p1_reg <= pw_sum[47:24];
            end
            if (state_reg == aue_pkg::ST_POW3) begin
                p2_reg <= pw_sum[47:24];
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    aue_pkg::REG_LEARNING_RATE: lr_reg <= cfg_wdata;
                    aue_pkg::REG_FIRST_DECAY: begin
                        b1_reg <= cfg_wdata;
                        p1_reg <= cfg_wdata;
                    end
                    aue_pkg::REG_SECOND_DECAY: begin
                        b2_reg <= cfg_wdata;
                        p2_reg <= cfg_wdata;
                    end
                    aue_pkg::REG_DENOMINATOR_FLOOR: eps_reg <= cfg_wdata;
                    default: ;  // drop writes to unknown registers
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // Moment memories
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            m_mem[mem_addr] <= mem_wm;
            v_mem[mem_addr] <= mem_wv;
        end
        rd_m_reg <= m_mem[aue_pkg::ADDR_W'(idx_reg)];
        rd_v_reg <= v_mem[aue_pkg::ADDR_W'(idx_reg)];
    end

    // ---------------------------------------------------------------
    // Datapath
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (s_tvalid && s_tready) begin
            grad_reg <= signed'(s_tdata[31:0]);
            idx_reg  <= s_tdata[42:32];
            last_reg <= s_tlast;
        end
        case (state_reg)
            aue_pkg::ST_READ:  upd_reg <= '0;
            aue_pkg::ST_MUL_B: acc_reg <= prod_reg[57:0] + {34'd0, aue_pkg::Q24_HALF};
            aue_pkg::ST_MUL_C: acc_reg <= acc_reg + prod_reg[57:0];
            aue_pkg::ST_MUL_D: begin
                mn_reg <= mn_sat;
                g2_reg <= g2_sum[62:16];
            end
            aue_pkg::ST_MUL_E: hi_reg <= prod_reg[49:0];
            aue_pkg::ST_MUL_F: hi_reg <= hi_reg + prod_reg[49:0];
            aue_pkg::ST_MUL_G: lo_reg <= prod_reg[49:0] + {26'd0, aue_pkg::Q24_HALF};
            aue_pkg::ST_MUL_H: lo_reg <= lo_reg + prod_reg[49:0];
            aue_pkg::ST_VN:    vn_reg <= vn;
            aue_pkg::ST_DIV_M: begin
                if (div_done) begin
                    mhat_reg <= div_sat;
                end
            end
            aue_pkg::ST_DIV_V: begin
                if (div_done) begin
                    // square root works on vhat * 2^16, or on vhat when that overflows
                    sq_small_reg <= (vhat[63:48] == 16'd0);
                    sq_x_reg     <= (vhat[63:48] == 16'd0) ? {vhat[47:0], 16'd0} : vhat;
                    sq_root_reg  <= '0;
                    sq_rem_reg   <= '0;
                    sq_cnt_reg   <= 6'd32;
                end
            end
            aue_pkg::ST_SQRT: begin
                if (sq_cnt_reg != 6'd0) begin
                    sq_cnt_reg  <= sq_cnt_reg - 1'b1;
                    sq_x_reg    <= {sq_x_reg[61:0], 2'b00};
                    sq_rem_reg  <= sq_ge ? (sq_rem2 - sq_trial) : sq_rem2;
                    sq_root_reg <= {sq_root_reg[30:0], sq_ge};
                end else begin
                    den_reg <= (den_sum == 41'd0) ? 41'd1 : den_sum;
                end
            end
            aue_pkg::ST_DIV_U: begin
                if (div_done) begin
                    upd_reg <= div_sat;
                end
            end
            default: ;
        endcase

        // divider: a load starts a new quotient, otherwise step while counting
        if (div_ld) begin
            div_rem_reg <= div_ld_hi;
            div_quo_reg <= div_ld_lo;
            div_den_reg <= div_ld_den;
            div_cnt_reg <= div_ld_ovf ? 7'd0 : div_ld_cnt;
            div_ovf_reg <= div_ld_ovf;
            div_neg_reg <= div_ld_neg;
        end else if (div_active && !div_done) begin
            div_rem_reg <= div_ge ? div_diff[40:0] : div_rem2[40:0];
            div_quo_reg <= {div_quo_reg[62:0], div_ge};
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Output register: hold a result until taken
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (state_reg == aue_pkg::ST_OUT && out_free) begin
            m_tvalid <= 1'b1;
        end else if (m_tready) begin
            m_tvalid <= 1'b0;
        end
        if (state_reg == aue_pkg::ST_OUT && out_free) begin
            m_tdata <= {5'd0, idx_reg, upd_reg};
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `AUE_ASSERT(a_accept_reads, (s_tvalid && s_tready) |=> (state_reg == aue_pkg::ST_READ), "accepted request did not start a memory read")
    `AUE_ASSERT(a_div_rem_bound, (div_active && !div_ovf_reg) |-> (div_rem_reg < div_den_reg), "divider remainder not below divisor")
    `AUE_ASSERT(a_power_source, ($past(aresetn) && !$stable(p1_reg)) |-> ($past(cfg_wr_en) || ($past(state_reg) == aue_pkg::ST_POW2)), "beta1 power changed without a write or pass end")
    `AUE_ASSERT(a_out_source, $rose(m_tvalid) |-> ($past(state_reg) == aue_pkg::ST_OUT), "result shown without a finished computation")

endmodule
`default_nettype wire
